@@ design/framed_command_receiver_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the framed command receiver
// Shared concurrent check forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECEIVER_DEFINES_SVH
`define FRAMED_COMMAND_RECEIVER_DEFINES_SVH

// Same-cycle implication.
`define FCR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fcr: same-cycle check failed");

// Next-cycle implication.
`define FCR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fcr: next-cycle check failed");

`endif

@@ design/fcr_pkg.sv @@
// ---------------------------------------------------------------------------
// fcr_pkg
// Constants, types and helpers shared by the frame receiver modules.
// ---------------------------------------------------------------------------
package fcr_pkg;

  localparam int unsigned MaxPayloadDefault = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CmdW  = 4;
  localparam int unsigned IdxW  = 5;

  localparam logic [ByteW-1:0] HdrFirst  = 8'hFD;
  localparam logic [ByteW-1:0] HdrSecond = 8'hDF;

  localparam logic [ByteW-1:0] CmdOne   = 8'h01;
  localparam logic [ByteW-1:0] CmdTwo   = 8'h02;
  localparam logic [ByteW-1:0] CmdThree = 8'h03;
  localparam logic [ByteW-1:0] CmdFour  = 8'h04;
  localparam logic [ByteW-1:0] CmdExt   = 8'h0A;

  typedef struct packed {
    logic            status;
    logic [CmdW-1:0] command;
    logic            has_payload;
  } fcr_desc_hdr_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } fcr_rel_t;

  function automatic logic cmd_known(input logic [ByteW-1:0] b);
    logic ok;
    case (b) inside
      CmdOne, CmdTwo, CmdThree, CmdFour, CmdExt: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

@@ design/fcr_desc_fifo.sv @@
// ---------------------------------------------------------------------------
// fcr_desc_fifo
// Two-entry queue of frame descriptors between parser and emitter.
// ---------------------------------------------------------------------------
module fcr_desc_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0] ent_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
      ent_q[0] <= '0;
      ent_q[1] <= '0;
    end else begin
      if (push_i) begin
        ent_q[wr_ptr_q] <= data_i;
        wr_ptr_q        <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ design/fcr_front.sv @@
// ---------------------------------------------------------------------------
// fcr_front
// Header hunt, command and length checks, payload capture and checksum.
// ---------------------------------------------------------------------------
`include "framed_command_receiver_defines.svh"

module fcr_front import fcr_pkg::*; #(
  parameter  int unsigned MaxPayload = MaxPayloadDefault,
  localparam int unsigned LenW       = $clog2(MaxPayload + 1),
  localparam int unsigned AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1,
  localparam int unsigned DescW      = $bits(fcr_desc_hdr_t) + 1 + LenW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             desc_full_i,
  output logic             desc_push_o,
  output logic [DescW-1:0] desc_o,
  output logic             wr_en_o,
  output logic [AddrW:0]   wr_addr_o,
  output logic [ByteW-1:0] wr_data_o,
  input  fcr_rel_t         rel_i
);

  typedef enum logic [1:0] {PH_HUNT, PH_CMD, PH_LEN, PH_DATA} phase_e;

  phase_e          phase_q;
  logic            hdr_seen_q;
  logic            inhibit_q;
  logic [LenW-1:0] cnt_q, len_q;
  logic [CmdW-1:0] cmd_q;
  logic [ByteW-1:0] xor_q;
  logic            bank_q;
  logic [1:0]      busy_q, busy_d;

  logic          accept, store, sum_good, has_pl;
  fcr_desc_hdr_t hdr;

  assign full     = desc_full_i | busy_q[bank_q];
  assign accept   = push & ~full;
  assign store    = (phase_q == PH_DATA) && (cnt_q < len_q);
  assign sum_good = (xor_q == rx_byte_i);
  assign has_pl   = sum_good && (len_q != '0);

  assign hdr.status      = ~sum_good;
  assign hdr.command     = cmd_q;
  assign hdr.has_payload = has_pl;

  assign desc_push_o = accept && (phase_q == PH_DATA) && !store;
  assign desc_o      = {hdr, bank_q, len_q};

  assign wr_en_o   = accept && store;
  assign wr_addr_o = {bank_q, cnt_q[AddrW-1:0]};
  assign wr_data_o = rx_byte_i;

  always_comb begin
    busy_d = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (desc_push_o && has_pl) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      hdr_seen_q <= 1'b0;
      inhibit_q  <= 1'b0;
      cnt_q      <= '0;
      len_q      <= '0;
      cmd_q      <= '0;
      xor_q      <= '0;
      bank_q     <= 1'b0;
      busy_q     <= '0;
    end else begin
      busy_q <= busy_d;
      if (cfg_we_i) begin
        inhibit_q <= cfg_wdata_i;
      end
      if (accept) begin
        unique case (phase_q)
          PH_HUNT: begin
            if (!hdr_seen_q) begin
              hdr_seen_q <= (rx_byte_i == HdrFirst);
            end else begin
              hdr_seen_q <= 1'b0;
              if (rx_byte_i == HdrSecond && !inhibit_q) begin
                phase_q <= PH_CMD;
              end
            end
          end
          PH_CMD: begin
            if (cmd_known(rx_byte_i)) begin
              cmd_q   <= rx_byte_i[CmdW-1:0];
              phase_q <= PH_LEN;
            end else begin
              phase_q <= PH_HUNT;
            end
          end
          PH_LEN: begin
            if (rx_byte_i <= ByteW'(MaxPayload)) begin
              len_q   <= rx_byte_i[LenW-1:0];
              xor_q   <= HdrFirst ^ HdrSecond ^ {{(ByteW-CmdW){1'b0}}, cmd_q} ^ rx_byte_i;
              cnt_q   <= '0;
              phase_q <= PH_DATA;
            end else begin
              phase_q <= PH_HUNT;
            end
          end
          PH_DATA: begin
            if (store) begin
              xor_q <= xor_q ^ rx_byte_i;
              cnt_q <= cnt_q + 1'b1;
            end else begin
              phase_q <= PH_HUNT;
              if (has_pl) begin
                bank_q <= ~bank_q;
              end
            end
          end
        endcase
      end
    end
  end

  `FCR_ASSERT_IMP(a_desc_no_overflow, desc_push_o, !desc_full_i)
  `FCR_ASSERT_IMP(a_wr_free_bank, wr_en_o, !busy_q[wr_addr_o[AddrW]])
  `FCR_ASSERT_IMP(a_rel_busy_bank, rel_i.valid, busy_q[rel_i.bank])

endmodule

@@ design/fcr_back.sv @@
// ---------------------------------------------------------------------------
// fcr_back
// Payload store and result emitter: one result item per stored byte of a good
// frame, and a single item for an empty or bad frame.
`include "framed_command_receiver_defines.svh"

module fcr_back import fcr_pkg::*; #(
  parameter  int unsigned MaxPayload = MaxPayloadDefault,
  localparam int unsigned LenW       = $clog2(MaxPayload + 1),
  localparam int unsigned AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1,
  localparam int unsigned DescW      = $bits(fcr_desc_hdr_t) + 1 + LenW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             desc_empty_i,
  input  logic [DescW-1:0] desc_i,
  output logic             desc_pop_o,
  input  logic             wr_en_i,
  input  logic [AddrW:0]   wr_addr_i,
  input  logic [ByteW-1:0] wr_data_i,
  output fcr_rel_t         rel_o,
  output logic             empty,
  input  logic             pop,
  output logic             status_o,
  output logic [CmdW-1:0]  command_o,
  output logic             has_payload_o,
  output logic [ByteW-1:0] payload_byte_o,
  output logic [IdxW-1:0]  byte_index_o,
  output logic             last_o
);

  typedef enum logic [1:0] {BK_IDLE, BK_READ, BK_EMIT} back_e;

  logic [ByteW-1:0] mem_q [2**(AddrW+1)];
  logic [ByteW-1:0] rd_q;

  back_e            st_q;
  logic             bank_q;
  logic [LenW-1:0]  len_q, idx_q;
  logic [CmdW-1:0]  cmd_q;

  logic             out_valid_q, out_status_q, out_has_q, out_last_q;
  logic [CmdW-1:0]  out_cmd_q;
  logic [ByteW-1:0] out_data_q;
  logic [IdxW-1:0]  out_idx_q;

  fcr_desc_hdr_t        hdr;
  logic                 out_free, is_last, emit_byte, out_load;
  logic [LenW+IdxW-1:0] idx_ext;

  assign hdr      = desc_i[DescW-1 -: $bits(fcr_desc_hdr_t)];
  assign out_free = !out_valid_q || pop;
  assign is_last  = ({1'b0, idx_q} + 1'b1) == {1'b0, len_q};
  assign idx_ext  = {{IdxW{1'b0}}, idx_q};

  assign desc_pop_o = (st_q == BK_IDLE) && !desc_empty_i && out_free;
  assign emit_byte  = (st_q == BK_EMIT) && out_free;
  assign out_load   = (desc_pop_o && !hdr.has_payload) || emit_byte;
  assign rel_o.valid = emit_byte && is_last;
  assign rel_o.bank  = bank_q;

  assign empty          = !out_valid_q;
  assign status_o       = out_status_q;
  assign command_o      = out_cmd_q;
  assign has_payload_o  = out_has_q;
  assign payload_byte_o = out_data_q;
  assign byte_index_o   = out_idx_q;
  assign last_o         = out_last_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[{bank_q, idx_q[AddrW-1:0]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= BK_IDLE;
      bank_q       <= 1'b0;
      len_q        <= '0;
      idx_q        <= '0;
      cmd_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_cmd_q    <= '0;
      out_has_q    <= 1'b0;
      out_data_q   <= '0;
      out_idx_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        BK_IDLE: begin
          if (desc_pop_o) begin
            cmd_q  <= hdr.command;
            bank_q <= desc_i[LenW];
            len_q  <= desc_i[LenW-1:0];
            idx_q  <= '0;
            if (hdr.has_payload) begin
              st_q <= BK_READ;
            end else begin
              out_status_q <= hdr.status;
              out_cmd_q    <= hdr.command;
              out_has_q    <= 1'b0;
              out_data_q   <= '0;
              out_idx_q    <= '0;
              out_last_q   <= 1'b1;
            end
          end
        end
        BK_READ: begin
          st_q <= BK_EMIT;
        end
        BK_EMIT: begin
          if (emit_byte) begin
            out_status_q <= 1'b0;
            out_cmd_q    <= cmd_q;
            out_has_q    <= 1'b1;
            out_data_q   <= rd_q;
            out_idx_q    <= idx_ext[IdxW-1:0];
            out_last_q   <= is_last;
            if (is_last) begin
              st_q <= BK_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
              st_q  <= BK_READ;
            end
          end
        end
        default: st_q <= BK_IDLE;
      endcase
    end
  end

  `FCR_ASSERT_IMP(a_idx_in_range, st_q != BK_IDLE, idx_q < len_q)
  `FCR_ASSERT_NEXT(a_last_lands, rel_o.valid, out_valid_q && out_last_q && st_q == BK_IDLE)
  `FCR_ASSERT_NEXT(a_single_item, desc_pop_o && !hdr.has_payload, out_valid_q && out_last_q && !out_has_q)

endmodule

@@ design/framed_command_receiver.sv @@
// ---------------------------------------------------------------------------
// framed_command_receiver
// Parses FD DF / command / length / payload / XOR checksum frames from a
// byte stream and releases the payload of each good frame item by item.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   input    | push, full                | rx_byte_i
//   result   | empty, pop                | status_o command_o has_payload_o
//            |                           | payload_byte_o byte_index_o last_o
//   config   | cfg_we_i                  | cfg_wdata_i (rx inhibit)
//
// Bytes are taken one per cycle while full is low; the parser finishes each
// byte in that cycle. A good frame drains byte by byte (payload RAM read,
// then the output register); error and empty frames give one result each.
// Payload RAM has two banks, so one frame may drain while the next is parsed;
// full rises when the bank being written is held or the descriptor queue is
// full. Reset is immediate: the RAM needs no clearing pass.
// ---------------------------------------------------------------------------
module framed_command_receiver import fcr_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             empty,
  input  logic             pop,
  output logic             status_o,
  output logic [CmdW-1:0]  command_o,
  output logic             has_payload_o,
  output logic [ByteW-1:0] payload_byte_o,
  output logic [IdxW-1:0]  byte_index_o,
  output logic             last_o,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i
);

  localparam int unsigned LenW  = $clog2(MaxPayload + 1);
  localparam int unsigned AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int unsigned DescW = $bits(fcr_desc_hdr_t) + 1 + LenW;

  logic             desc_push, desc_full, desc_pop, desc_empty;
  logic [DescW-1:0] desc_in, desc_out;
  logic             wr_en;
  logic [AddrW:0]   wr_addr;
  logic [ByteW-1:0] wr_data;
  fcr_rel_t         rel;

  fcr_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .desc_full_i (desc_full),
    .desc_push_o (desc_push),
    .desc_o      (desc_in),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rel_i       (rel)
  );

  fcr_desc_fifo #(
    .Width(DescW)
  ) u_desc_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .data_i  (desc_in),
    .full_o  (desc_full),
    .pop_i   (desc_pop),
    .data_o  (desc_out),
    .empty_o (desc_empty)
  );

  fcr_back #(
    .MaxPayload(MaxPayload)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .desc_empty_i   (desc_empty),
    .desc_i         (desc_out),
    .desc_pop_o     (desc_pop),
    .wr_en_i        (wr_en),
    .wr_addr_i      (wr_addr),
    .wr_data_i      (wr_data),
    .rel_o          (rel),
    .empty          (empty),
    .pop            (pop),
    .status_o       (status_o),
    .command_o      (command_o),
    .has_payload_o  (has_payload_o),
    .payload_byte_o (payload_byte_o),
    .byte_index_o   (byte_index_o),
    .last_o         (last_o)
  );

endmodule

@@ verif/fcr_frame_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame receiver checker
// Watches the byte and result queues of the frame receiver and runs its own
// frame parser on every accepted byte. The parser keeps the expected results
// in order; each popped result is compared field by field with the oldest.
// It reports the number of mismatches and the results still due.
// ---------------------------------------------------------------------------
module fcr_frame_checker import fcr_pkg::*; #(
  parameter int unsigned MaxPayload = MaxPayloadDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             full_i,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic             empty_i,
  input  logic             pop_i,
  input  logic             status_i,
  input  logic [CmdW-1:0]  command_i,
  input  logic             has_payload_i,
  input  logic [ByteW-1:0] payload_byte_i,
  input  logic [IdxW-1:0]  byte_index_i,
  input  logic             last_i,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  output int unsigned      mismatches_o,
  output int unsigned      outstanding_o
);

  typedef enum logic [1:0] {
    ParseHunt,
    ParseCommand,
    ParseLength,
    ParseBody
  } parse_state_e;

  typedef struct packed {
    logic             status;
    logic [CmdW-1:0]  command;
    logic             has_payload;
    logic [ByteW-1:0] payload_byte;
    logic [IdxW-1:0]  byte_index;
    logic             last;
  } frame_result_t;

  frame_result_t    due_results[$];
  parse_state_e     state_q = ParseHunt;
  logic             saw_first_q = 1'b0;
  logic             inhibit_q = 1'b0;
  logic [ByteW-1:0] cmd_byte_q = '0;
  logic [ByteW-1:0] xor_q = '0;
  int unsigned      length_q = 0;
  int unsigned      count_q = 0;
  logic [ByteW-1:0] body_q [MaxPayload];

  function automatic bit is_known_cmd(input logic [ByteW-1:0] b);
    return b == CmdOne || b == CmdTwo || b == CmdThree || b == CmdFour || b == CmdExt;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatches_o < 200) begin
      $display("%0t fcr check: %s got 0x%0h want 0x%0h", $time, what, got, want);
    end
    mismatches_o++;
  endtask

  task automatic return_to_hunt();
    state_q = ParseHunt;
    saw_first_q = 1'b0;
    count_q = 0;
    cmd_byte_q = '0;
    length_q = 0;
    xor_q = '0;
  endtask

  task automatic consume_byte(input logic [ByteW-1:0] b);
    frame_result_t r;
    case (state_q)
      ParseHunt: begin
        if (!saw_first_q) begin
          saw_first_q = (b == HdrFirst);
        end else begin
          saw_first_q = 1'b0;
          if (b == HdrSecond && !inhibit_q) state_q = ParseCommand;
        end
      end
      ParseCommand: begin
        if (is_known_cmd(b)) begin
          cmd_byte_q = b;
          state_q = ParseLength;
        end else begin
          return_to_hunt();
        end
      end
      ParseLength: begin
        if (b <= MaxPayload) begin
          length_q = b;
          xor_q = HdrFirst ^ HdrSecond ^ cmd_byte_q ^ b;
          count_q = 0;
          state_q = ParseBody;
        end else begin
          return_to_hunt();
        end
      end
      default: begin
        if (count_q < length_q && count_q < MaxPayload) begin
          body_q[count_q] = b;
          xor_q ^= b;
          count_q++;
        end else begin
          r = '0;
          r.command = cmd_byte_q[CmdW-1:0];
          r.last = 1'b1;
          if (xor_q != b) begin
            r.status = 1'b1;
            due_results.push_back(r);
          end else if (length_q == 0) begin
            due_results.push_back(r);
          end else begin
            for (int i = 0; i < length_q && i < MaxPayload; i++) begin
              r.has_payload = 1'b1;
              r.payload_byte = body_q[i];
              r.byte_index = i[IdxW-1:0];
              r.last = (i + 1 == length_q);
              due_results.push_back(r);
            end
          end
          return_to_hunt();
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    frame_result_t seen;
    frame_result_t want;
    if (!rst_ni) begin
      due_results.delete();
      inhibit_q = 1'b0;
      mismatches_o = 0;
      return_to_hunt();
      outstanding_o <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        seen = {status_i, command_i, has_payload_i, payload_byte_i, byte_index_i, last_i};
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing due", seen, 0);
        end else begin
          want = due_results.pop_front();
          if (seen.status != want.status)
            report_mismatch("status", seen.status, want.status);
          if (seen.command != want.command)
            report_mismatch("command", seen.command, want.command);
          if (seen.has_payload != want.has_payload)
            report_mismatch("has_payload", seen.has_payload, want.has_payload);
          if (seen.payload_byte != want.payload_byte)
            report_mismatch("payload_byte", seen.payload_byte, want.payload_byte);
          if (seen.byte_index != want.byte_index)
            report_mismatch("byte_index", seen.byte_index, want.byte_index);
          if (seen.last != want.last)
            report_mismatch("last", seen.last, want.last);
        end
      end
      if (cfg_we_i) inhibit_q = cfg_wdata_i;
      if (push_i && !full_i) consume_byte(rx_byte_i);
      outstanding_o <= due_results.size();
    end
  end

endmodule

@@ verif/tb_framed_command_receiver.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frame receiver testbench
// Feeds the receiver directed frames (empty, single byte, bad checksum,
// unknown command, oversize length, broken headers, receive inhibit), then
// mostly well-formed random frames mixed with noise, under random stalls on
// both queues apart from one stall-free stretch, and both inhibit settings. A
// checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_framed_command_receiver import fcr_pkg::*;;

  localparam int unsigned IdleSettle = 8;
  localparam int unsigned StallLimit = 4000;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [ByteW-1:0] rx_byte = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic             status;
  logic [CmdW-1:0]  command;
  logic             has_payload;
  logic [ByteW-1:0] payload_byte;
  logic [IdxW-1:0]  byte_index;
  logic             last;
  logic             cfg_we = 1'b0;
  logic             cfg_wdata = 1'b0;
  int unsigned      mismatches;
  int unsigned      outstanding;
  int unsigned      frame_bytes = 0;
  int unsigned      idle_cycles = 0;
  bit               steady = 1'b0;

  framed_command_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .rx_byte_i     (rx_byte),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status),
    .command_o     (command),
    .has_payload_o (has_payload),
    .payload_byte_o(payload_byte),
    .byte_index_o  (byte_index),
    .last_o        (last),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata)
  );

  fcr_frame_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .rx_byte_i     (rx_byte),
    .empty_i       (empty),
    .pop_i         (pop),
    .status_i      (status),
    .command_i     (command),
    .has_payload_i (has_payload),
    .payload_byte_i(payload_byte),
    .byte_index_i  (byte_index),
    .last_i        (last),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin : drain
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  function automatic logic [ByteW-1:0] pick_known_cmd();
    case ($urandom_range(0, 4))
      0: return CmdOne;
      1: return CmdTwo;
      2: return CmdThree;
      3: return CmdFour;
      default: return CmdExt;
    endcase
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (full);
  endtask

  // fill < 0 draws random payload bytes
  task automatic send_frame(input logic [ByteW-1:0] cmd, input int unsigned len,
                            input bit corrupt, input int fill);
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] data;
    sum = HdrFirst ^ HdrSecond ^ cmd ^ len[ByteW-1:0];
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    send_byte(cmd);
    send_byte(len[ByteW-1:0]);
    frame_bytes += 4;
    if (len <= MaxPayloadDefault) begin
      for (int i = 0; i < len; i++) begin
        data = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[ByteW-1:0];
        sum ^= data;
        send_byte(data);
      end
      if (corrupt) sum ^= 8'($urandom_range(1, 255));
      send_byte(sum);
      frame_bytes += len + 1;
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (IdleSettle) @(posedge clk_i);
  endtask

  task automatic write_inhibit(input logic value);
    wait_idle();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(input int unsigned byte_goal);
    int unsigned pick;
    int unsigned len;
    logic [ByteW-1:0] cmd;
    while (frame_bytes < byte_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        len = ($urandom_range(0, 11) == 0) ? MaxPayloadDefault : $urandom_range(0, 6);
        send_frame(pick_known_cmd(), len, $urandom_range(0, 6) == 0, -1);
      end else if (pick < 85) begin
        cmd = $urandom_range(0, 1) ? 8'($urandom_range(11, 255)) : 8'($urandom_range(5, 9));
        send_frame(cmd, $urandom_range(0, 4), 1'b0, -1);
      end else if (pick < 91) begin
        send_frame(pick_known_cmd(), $urandom_range(MaxPayloadDefault + 1, 255), 1'b0, -1);
      end else if (pick < 95) begin
        send_byte(HdrFirst);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_inhibit(1'b0);

    send_frame(CmdOne, 0, 1'b0, -1);
    send_frame(CmdTwo, 1, 1'b0, 8'hFF);
    send_frame(CmdThree, 2, 1'b0, 8'h00);
    send_frame(CmdFour, 1, 1'b1, -1);
    send_frame(CmdExt, 0, 1'b1, -1);
    send_frame(8'h00, 0, 1'b0, -1);
    send_frame(CmdExt, MaxPayloadDefault + 1, 1'b0, -1);
    send_byte(HdrSecond);
    send_byte(8'h00);
    send_byte(HdrFirst);
    send_byte(HdrFirst);
    send_byte(HdrSecond);
    send_frame(CmdExt, 1, 1'b0, -1);

    write_inhibit(1'b1);
    send_frame(CmdOne, 1, 1'b0, -1);
    write_inhibit(1'b0);
    send_frame(CmdExt, MaxPayloadDefault, 1'b0, -1);

    random_traffic(frame_bytes + 60);
    steady = 1'b1;
    random_traffic(frame_bytes + 30);
    steady = 1'b0;
    write_inhibit(1'b1);
    random_traffic(frame_bytes + 25);
    write_inhibit(1'b0);
    random_traffic(frame_bytes + 70);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/fcr_pkg.sv
design/fcr_desc_fifo.sv
design/fcr_front.sv
design/fcr_back.sv
design/framed_command_receiver.sv
verif/fcr_frame_checker.sv
verif/tb_framed_command_receiver.sv
